FILE: rtl/sre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sre_pkg;

    localparam int MAX_LEN = 1024;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQ     = 8'd34;
    localparam logic [7:0] CH_SQ     = 8'd39;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_BSL    = 8'd92;
    localparam logic [7:0] CH_N      = 8'd110;
    localparam logic [7:0] CH_R      = 8'd114;
    localparam logic [7:0] CH_T      = 8'd116;
    localparam logic [7:0] CH_X      = 8'd120;
    localparam logic [7:0] CH_DEL    = 8'd127;
    // 'a' minus ten
    localparam logic [7:0] HEX_A_OFS = 8'd87;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_END  = 2'd1,
        MODE_PULL = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OUT_EMPTY,
        OUT_QUOTE,
        OUT_CLOSE,
        OUT_ESC
    } t_out_sel;

    typedef struct packed {
        logic     clear;
        logic     load;
        logic     start_emit;
        logic     rd_en;
        logic     emit_inc;
        logic     out_write;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_lt_count;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [31:0] chars;
        logic [2:0]  len;
    } t_esc;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] w;
        w = {4'd0, n};
        return (n < 4'd10) ? (CH_ZERO + w) : (HEX_A_OFS + w);
    endfunction

    function automatic t_esc escape_byte(input logic [7:0] c, input logic [7:0] q);
        t_esc e;
        e.chars = '0;
        e.len   = 3'd2;
        if (c == CH_BSL) begin
            e.chars = {16'd0, CH_BSL, CH_BSL};
        end else if (c == q) begin
            e.chars = {16'd0, q, CH_BSL};
        end else if (c == CH_TAB) begin
            e.chars = {16'd0, CH_T, CH_BSL};
        end else if (c == CH_LF) begin
            e.chars = {16'd0, CH_N, CH_BSL};
        end else if (c == CH_CR) begin
            e.chars = {16'd0, CH_R, CH_BSL};
        end else if (c >= CH_SPACE && c < CH_DEL) begin
            e.chars = {24'd0, c};
            e.len   = 3'd1;
        end else begin
            e.chars = {hex_digit(c[3:0]), hex_digit(c[7:4]), CH_X, CH_BSL};
            e.len   = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/string_repr_escaper_unit.sv
// String repr escaper.
// Input channel (i_in_valid / o_in_stall) carries items of i_mode and
// i_data_byte: load one byte, end of string, or pull the next output group.
// Output channel (o_out_valid / i_out_stall) carries one group per pull:
// up to four characters, their count, a closing-quote flag and a truncation
// flag. Loads and end-of-string give no output item.
// A pull of a quote or of an empty group lands in the output register at the
// accepting edge; a pull of a stored byte first reads the registered read port
// of the 1024-entry byte buffer, then writes the output register once it is
// free, and the input is stalled until that write.
// Input is stalled whenever the output register holds an item the receiver
// is stalling, so results are never dropped; a stalled item holds steady.
// Reset (synchronous, active low) empties the buffer count, clears the quote
// and overflow flags, returns to the loading phase and drops any pending
// output item. Buffer contents are not cleared; only written entries are read.
`timescale 1ns / 1ps
`default_nettype none

module string_repr_escaper_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_group_chars,
    output logic [2:0]       o_group_length,
    output logic             o_final_group,
    output logic             o_truncated
);
    import sre_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    sre_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_data_byte    (i_data_byte),
        .i_out_stall    (i_out_stall),
        .o_sts          (w_sts),
        .o_out_valid    (o_out_valid),
        .o_group_chars  (o_group_chars),
        .o_group_length (o_group_length),
        .o_final_group  (o_final_group),
        .o_truncated    (o_truncated)
    );

endmodule

`default_nettype wire

FILE: rtl/sre_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sre_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_mode,
    input  wire sre_pkg::t_dp_sts i_sts,
    output logic                  o_in_stall,
    output sre_pkg::t_dp_cmd      o_cmd
);
    import sre_pkg::*;

    typedef enum logic [2:0] {
        ST_LOADING,
        ST_OPENING,
        ST_BODY,
        ST_BODY_READ,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;
    t_mode  w_mode;

    always_comb begin
        o_in_stall = (r_state == ST_BODY_READ) || !i_sts.out_free;
        w_accept   = i_in_valid && !o_in_stall;
        w_mode     = t_mode'(i_mode);
        o_cmd      = '0;
        n_state    = r_state;
        if (r_state == ST_BODY_READ) begin
            // read data is registered; emit once the output register is free
            if (i_sts.out_free) begin
                o_cmd.out_write = 1'b1;
                o_cmd.out_sel   = OUT_ESC;
                o_cmd.emit_inc  = 1'b1;
                n_state         = ST_BODY;
            end
        end else if (w_accept) begin
            unique case (w_mode)
                MODE_LOAD: begin
                    if (r_state == ST_DONE) begin
                        o_cmd.clear = 1'b1;
                        o_cmd.load  = 1'b1;
                        n_state     = ST_LOADING;
                    end else if (r_state == ST_LOADING) begin
                        o_cmd.load = 1'b1;
                    end
                end
                MODE_END: begin
                    if (r_state == ST_DONE || r_state == ST_LOADING) begin
                        o_cmd.clear      = (r_state == ST_DONE);
                        o_cmd.start_emit = 1'b1;
                        n_state          = ST_OPENING;
                    end
                end
                MODE_PULL: begin
                    unique case (r_state)
                        ST_OPENING: begin
                            o_cmd.out_write = 1'b1;
                            o_cmd.out_sel   = OUT_QUOTE;
                            n_state         = ST_BODY;
                        end
                        ST_BODY: begin
                            if (i_sts.emit_lt_count) begin
                                o_cmd.rd_en = 1'b1;
                                n_state     = ST_BODY_READ;
                            end else begin
                                o_cmd.out_write = 1'b1;
                                o_cmd.out_sel   = OUT_CLOSE;
                                n_state         = ST_DONE;
                            end
                        end
                        default: begin
                            o_cmd.out_write = 1'b1;
                            o_cmd.out_sel   = OUT_EMPTY;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOADING;
        end else begin
            r_state <= n_state;
        end
    end

    a_read_from_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BODY_READ |-> $past(r_state) == ST_BODY || $past(r_state) == ST_BODY_READ)
        else $error("body read entered from wrong phase");

    a_write_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_write |-> i_sts.out_free)
        else $error("output written while occupied");

endmodule

`default_nettype wire

FILE: rtl/sre_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sre_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sre_pkg::t_dp_cmd i_cmd,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_out_stall,
    output sre_pkg::t_dp_sts      o_sts,
    output logic                  o_out_valid,
    output logic [31:0]           o_group_chars,
    output logic [2:0]            o_group_length,
    output logic                  o_final_group,
    output logic                  o_truncated
);
    import sre_pkg::*;

    logic [7:0]        mem [MAX_LEN];
    logic [7:0]        r_rd_data;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_emit, n_emit;
    logic              r_sq, n_sq;
    logic              r_dq, n_dq;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  w_base;
    logic              w_wr;
    logic [7:0]        w_quote;
    t_esc              w_esc;
    logic              r_out_valid;
    logic [31:0]       r_chars;
    logic [2:0]        r_len;
    logic              r_final;
    logic              r_trunc;

    always_comb begin
        n_count = r_count;
        n_emit  = r_emit;
        n_sq    = r_sq;
        n_dq    = r_dq;
        n_ovf   = r_ovf;
        w_wr    = 1'b0;
        if (i_cmd.clear) begin
            n_count = '0;
            n_emit  = '0;
            n_sq    = 1'b0;
            n_dq    = 1'b0;
            n_ovf   = 1'b0;
        end
        w_base = n_count;
        if (i_cmd.load) begin
            if (w_base < CNT_W'(MAX_LEN)) begin
                w_wr    = 1'b1;
                n_count = w_base + 1'b1;
                n_sq    = n_sq || (i_data_byte == CH_SQ);
                n_dq    = n_dq || (i_data_byte == CH_DQ);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.start_emit) begin
            n_emit = '0;
        end else if (i_cmd.emit_inc) begin
            n_emit = r_emit + 1'b1;
        end
        w_quote = (r_sq && !r_dq) ? CH_DQ : CH_SQ;
        w_esc   = escape_byte(r_rd_data, w_quote);
        o_sts.out_free      = !r_out_valid || !i_out_stall;
        o_sts.emit_lt_count = r_emit < r_count;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_base[ADDR_W-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_emit[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_emit      <= '0;
            r_sq        <= 1'b0;
            r_dq        <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_emit  <= n_emit;
            r_sq    <= n_sq;
            r_dq    <= n_dq;
            r_ovf   <= n_ovf;
            if (i_cmd.out_write) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_trunc <= r_ovf;
            r_final <= (i_cmd.out_sel == OUT_CLOSE);
            case (i_cmd.out_sel)
                OUT_QUOTE, OUT_CLOSE: begin
                    r_chars <= {24'd0, w_quote};
                    r_len   <= 3'd1;
                end
                OUT_ESC: begin
                    r_chars <= w_esc.chars;
                    r_len   <= w_esc.len;
                end
                default: begin
                    r_chars <= '0;
                    r_len   <= 3'd0;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_group_chars  = r_chars;
    assign o_group_length = r_len;
    assign o_final_group  = r_final;
    assign o_truncated    = r_trunc;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("stored count beyond capacity");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= r_count)
        else $error("emit position past stored count");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.load && !i_cmd.clear |=> $stable(r_count))
        else $error("count changed without load or clear");

endmodule

`default_nettype wire

FILE: sim/sre_checker.sv
`timescale 1ns / 1ps

module sre_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_group_chars,
    input  wire logic [2:0]  i_group_length,
    input  wire logic        i_final_group,
    input  wire logic        i_truncated,
    output int               o_err_count,
    output int               o_pending,
    output int               o_groups
);
    import sre_pkg::*;

    localparam int MAX_SHOWN = 100;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_OPEN,
        ST_BODY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] chars;
        logic [2:0]  len;
        logic        fin;
        logic        trunc;
    } t_group;

    logic [7:0]  str_mem [MAX_LEN];
    int unsigned n_stored;
    int unsigned n_emitted;
    t_state      state;
    logic        has_sq;
    logic        has_dq;
    logic        dropped;
    t_group      group_q[$];
    int          errs = 0;
    int          seen = 0;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_groups    = 0;
    end

    function automatic logic [7:0] delim();
        return (has_sq && !has_dq) ? CH_DQ : CH_SQ;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + {4'd0, n} : HEX_A_OFS + {4'd0, n};
    endfunction

    function automatic t_group escape_group(input logic [7:0] c, input logic [7:0] q);
        t_group          g;
        logic [3:0][7:0] ch;
        g  = '0;
        ch = '0;
        if (c == CH_BSL || c == q) begin
            ch[0] = CH_BSL;
            ch[1] = c;
            g.len = 3'd2;
        end else if (c == CH_TAB) begin
            ch[0] = CH_BSL;
            ch[1] = CH_T;
            g.len = 3'd2;
        end else if (c == CH_LF) begin
            ch[0] = CH_BSL;
            ch[1] = CH_N;
            g.len = 3'd2;
        end else if (c == CH_CR) begin
            ch[0] = CH_BSL;
            ch[1] = CH_R;
            g.len = 3'd2;
        end else if (c >= CH_SPACE && c < CH_DEL) begin
            ch[0] = c;
            g.len = 3'd1;
        end else begin
            ch[0] = CH_BSL;
            ch[1] = CH_X;
            ch[2] = hex_char(c[7:4]);
            ch[3] = hex_char(c[3:0]);
            g.len = 3'd4;
        end
        g.chars = ch;
        return g;
    endfunction

    task automatic clear_string();
        n_stored  = 0;
        n_emitted = 0;
        state     = ST_LOAD;
        has_sq    = 1'b0;
        has_dq    = 1'b0;
        dropped   = 1'b0;
    endtask

    task automatic track_item(input logic [1:0] m, input logic [7:0] b);
        t_mode  md;
        t_group g;
        md = t_mode'(m);
        g  = '0;
        if (md == MODE_LOAD || md == MODE_END) begin
            if (state == ST_DONE) clear_string();
            if (state == ST_LOAD) begin
                if (md == MODE_END) begin
                    state     = ST_OPEN;
                    n_emitted = 0;
                end else if (n_stored < MAX_LEN) begin
                    str_mem[n_stored] = b;
                    n_stored++;
                    if (b == CH_SQ) has_sq = 1'b1;
                    if (b == CH_DQ) has_dq = 1'b1;
                end else begin
                    dropped = 1'b1;
                end
            end
        end else if (md == MODE_PULL) begin
            if (state == ST_OPEN) begin
                g.chars = {24'd0, delim()};
                g.len   = 3'd1;
                state   = ST_BODY;
            end else if (state == ST_BODY) begin
                if (n_emitted < n_stored) begin
                    g = escape_group(str_mem[n_emitted], delim());
                    n_emitted++;
                end else begin
                    g.chars = {24'd0, delim()};
                    g.len   = 3'd1;
                    g.fin   = 1'b1;
                    state   = ST_DONE;
                end
            end
            g.trunc = dropped;
            group_q.push_back(g);
        end
    endtask

    task automatic check_group();
        t_group want;
        seen++;
        if (group_q.size() == 0) begin
            if (errs < MAX_SHOWN)
                $display("%0t: unexpected group, chars %h length %0d", $time,
                         i_group_chars, i_group_length);
            errs++;
        end else begin
            want = group_q.pop_front();
            if (i_group_chars !== want.chars) begin
                if (errs < MAX_SHOWN)
                    $display("%0t: group_chars expected %h got %h", $time,
                             want.chars, i_group_chars);
                errs++;
            end
            if (i_group_length !== want.len) begin
                if (errs < MAX_SHOWN)
                    $display("%0t: group_length expected %0d got %0d", $time,
                             want.len, i_group_length);
                errs++;
            end
            if (i_final_group !== want.fin) begin
                if (errs < MAX_SHOWN)
                    $display("%0t: final_group expected %b got %b", $time,
                             want.fin, i_final_group);
                errs++;
            end
            if (i_truncated !== want.trunc) begin
                if (errs < MAX_SHOWN)
                    $display("%0t: truncated expected %b got %b", $time,
                             want.trunc, i_truncated);
                errs++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_string();
            group_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_group();
            if (i_in_valid && !i_in_stall) track_item(i_mode, i_data_byte);
        end
        o_err_count <= errs;
        o_pending   <= group_q.size();
        o_groups    <= seen;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sre_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_LEN     = MAX_LEN + 5;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [1:0]  in_mode    = MODE_NONE;
    logic [7:0]  in_byte    = 8'd0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [31:0] grp_chars;
    logic [2:0]  grp_len;
    logic        grp_final;
    logic        grp_trunc;
    int          err_count;
    int          pending;
    int          groups;

    logic [7:0]  str_buf [LONG_LEN];
    int          str_len;
    int          n_items = 0;
    bit          quiet   = 1'b0;

    string_repr_escaper_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (in_mode),
        .i_data_byte    (in_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_group_chars  (grp_chars),
        .o_group_length (grp_len),
        .o_final_group  (grp_final),
        .o_truncated    (grp_trunc)
    );

    sre_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_mode         (in_mode),
        .i_data_byte    (in_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_group_chars  (grp_chars),
        .i_group_length (grp_len),
        .i_final_group  (grp_final),
        .i_truncated    (grp_trunc),
        .o_err_count    (err_count),
        .o_pending      (pending),
        .o_groups       (groups)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_gap();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 5))
                    0: c = CH_SQ;
                    1: c = CH_DQ;
                    2: c = CH_BSL;
                    3: c = CH_TAB;
                    4: c = CH_LF;
                    default: c = CH_CR;
                endcase
            end
            2, 3: c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(32, 126));
        endcase
        return c;
    endfunction

    task automatic send_item(input t_mode m, input logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= m;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (m != MODE_NONE) n_items++;
    endtask

    task automatic load_string();
        for (int i = 0; i < str_len; i++) send_item(MODE_LOAD, str_buf[i]);
        send_item(MODE_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic pull_groups(input int n);
        repeat (n) send_item(MODE_PULL, 8'($urandom_range(0, 255)));
    endtask

    // receiver side: per item stall draw, then wait for the handshake
    initial begin
        wait (rst_n);
        forever begin
            int hold;
            hold = idle_gap();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int base;
        int kind;
        logic [7:0] b;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty group before any string, then an unused mode
        send_item(MODE_PULL, 8'h00);
        send_item(MODE_NONE, 8'hff);

        // single quote only: delimiter flips to double quote
        str_len    = 10;
        str_buf[0] = CH_BSL;
        str_buf[1] = CH_SQ;
        str_buf[2] = CH_TAB;
        str_buf[3] = CH_LF;
        str_buf[4] = CH_CR;
        str_buf[5] = CH_SPACE;
        str_buf[6] = 8'h7e;
        str_buf[7] = CH_DEL;
        str_buf[8] = 8'h00;
        str_buf[9] = 8'hff;
        load_string();
        send_item(MODE_LOAD, 8'h41);
        send_item(MODE_END, 8'h00);
        pull_groups(1);
        send_item(MODE_LOAD, 8'h42);
        pull_groups(str_len + 2);

        // both quotes: single-quote delimiter, single quote escaped
        str_len    = 2;
        str_buf[0] = CH_DQ;
        str_buf[1] = CH_SQ;
        load_string();
        pull_groups(5);

        // end straight after done starts an empty string
        send_item(MODE_END, 8'h55);
        pull_groups(3);

        // overflow: dropped quotes must not move the delimiter
        str_len = LONG_LEN;
        for (int i = 0; i < MAX_LEN; i++) begin
            b = 8'($urandom_range(0, 255));
            str_buf[i] = (b == CH_DQ) ? CH_DQ + 8'd1 : b;
        end
        str_buf[3]           = CH_SQ;
        str_buf[MAX_LEN]     = CH_DQ;
        str_buf[MAX_LEN + 1] = CH_DQ;
        str_buf[MAX_LEN + 2] = CH_SQ;
        str_buf[MAX_LEN + 3] = 8'h00;
        str_buf[MAX_LEN + 4] = 8'hff;
        for (int i = 0; i < str_len; i++) send_item(MODE_LOAD, str_buf[i]);
        send_item(MODE_PULL, 8'haa);
        send_item(MODE_END, 8'h00);
        pull_groups(MAX_LEN + 3);

        base = n_items;
        while (n_items < base + RANDOM_ITEMS) begin
            quiet   = ($urandom_range(0, 4) == 0);
            kind    = $urandom_range(0, 9);
            str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(0, 12);
            for (int i = 0; i < str_len; i++) str_buf[i] = pick_char();
            if (kind == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(t_mode'(2'($urandom_range(0, 3))),
                              8'($urandom_range(0, 255)));
            end else if (kind == 1) begin
                load_string();
                pull_groups($urandom_range(0, str_len + 3));
            end else begin
                load_string();
                pull_groups(str_len + 2 + $urandom_range(0, 1));
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d items and checked %0d output groups: escapes, quote choice,",
                 n_items, groups);
        $display("ignored modes, empty strings and a %0d-byte string past capacity.",
                 LONG_LEN);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
